// ----- src/assert_macros.svh -----
// Assertion macros shared by the framebuffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define XSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define XSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/xsf_pkg.sv -----
// Types and constants for the sprite-draw framebuffer.
package xsf_pkg;

  localparam int FRAME_WIDTH_DEF  = 64;
  localparam int FRAME_HEIGHT_DEF = 32;
  localparam int SPRITE_PIXELS    = 8;
  localparam int PIX_CNT_W        = $clog2(SPRITE_PIXELS);

  typedef enum logic [1:0] {
    OP_FILL = 2'd0,
    OP_DRAW = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_PIX,
    ST_WRITE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [3:0] row_offset;
    logic [7:0] sprite_bits;
    logic       last_row;
    logic       fill_bit;
  } in_item_t;

  typedef struct packed {
    logic collision;
    logic pixel_value;
    logic sprite_done;
    logic out_of_range;
  } out_item_t;

  // Control from the sequencer to the frame store.
  typedef struct packed {
    logic fill;
    logic fill_bit;
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ----- src/xsf_frame_mem.sv -----
// Frame store: one row per address, per-row valid bits, constant-time fill.
module xsf_frame_mem
  import xsf_pkg::*;
#(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
  parameter int ROW_W        = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mem_ctl_t               ctl,
  input  logic [ROW_W-1:0]       rd_addr,
  input  logic [ROW_W-1:0]       wr_addr,
  input  logic [FRAME_WIDTH-1:0] wr_data,
  output logic [FRAME_WIDTH-1:0] rd_data
);

  logic [FRAME_WIDTH-1:0]  mem [FRAME_HEIGHT];
  logic [FRAME_HEIGHT-1:0] valid_r;
  logic                    fill_val_r;
  logic [FRAME_WIDTH-1:0]  rd_mem_r;
  logic                    rd_valid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_mem_r <= mem[rd_addr];
    end
  end

  // A row not written since the last fill reads as the fill pattern.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      fill_val_r <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl.fill) begin
        valid_r    <= '0;
        fill_val_r <= ctl.fill_bit;
      end else if (ctl.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_mem_r : {FRAME_WIDTH{fill_val_r}};

endmodule

// ----- src/xsf_pixel_alu.sv -----
// Shared per-pixel step: range check, collision test and XOR of one column.
module xsf_pixel_alu
  import xsf_pkg::*;
#(
  parameter int FRAME_WIDTH = FRAME_WIDTH_DEF,
  parameter int COL_W       = $clog2(FRAME_WIDTH + SPRITE_PIXELS),
  parameter int IDX_W       = $clog2(FRAME_WIDTH)
) (
  input  logic [FRAME_WIDTH-1:0] row_in,
  input  logic [COL_W-1:0]       col,
  input  logic                   sprite_pix,
  output logic [FRAME_WIDTH-1:0] row_out,
  output logic                   hit
);

  logic             in_range;
  logic             flip;
  logic [IDX_W-1:0] idx;

  always_comb begin
    in_range = (col < COL_W'(FRAME_WIDTH));
    flip     = in_range && sprite_pix;
    idx      = col[IDX_W-1:0];
    hit      = flip && row_in[idx];
    for (int i = 0; i < FRAME_WIDTH; i++) begin
      row_out[i] = row_in[i] ^ (flip && (idx == IDX_W'(i)));
    end
  end

endmodule

// ----- src/xor_sprite_framebuffer.sv -----
// Top level: sequencer, output register and framebuffer datapath.
//
//  channel | ports                           | word
//  --------+---------------------------------+------------------------------
//  input   | in_valid, in_stall, in_data     | operation and sprite/coords
//  output  | out_valid, out_stall, out_data  | collision, pixel, done, range
//
// A draw word passes from its accept to the next accept through idle, fetch,
// load, 8 pixel steps through the shared pixel unit, write back and result. Read
// passes through idle, fetch, load and result; fill, the unused code, an out-of-range
// read and a row below the bottom edge go from idle to result. The memory's single
// read port and the pixel unit set the rate. Reset clears the frame through per-row valid bits.
// A result waits in the output register while out_stall is high; the block takes
// the next word once the result is loaded, and holds in its result state only if
// the previous result has not been taken.
module xor_sprite_framebuffer
  import xsf_pkg::*;
#(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

`include "assert_macros.svh"

  localparam int ROW_W  = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
  localparam int RSUM_W = $clog2(FRAME_HEIGHT + 16);
  localparam int COL_W  = $clog2(FRAME_WIDTH + SPRITE_PIXELS);
  localparam int IDX_W  = $clog2(FRAME_WIDTH);

  state_t                 state_r, state_nxt;
  logic [1:0]             op_r, op_nxt;
  logic [COL_W-1:0]       col_r, col_nxt;
  logic [7:0]             sprite_r, sprite_nxt;
  logic [ROW_W-1:0]       addr_r, addr_nxt;
  logic [IDX_W-1:0]       pidx_r, pidx_nxt;
  logic                   last_r, last_nxt;
  logic                   oor_r, oor_nxt;
  logic                   pixel_r, pixel_nxt;
  logic                   acc_r, acc_nxt;
  logic [PIX_CNT_W-1:0]   k_r, k_nxt;
  logic [FRAME_WIDTH-1:0] row_r, row_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  mem_ctl_t               mem_ctl;
  logic [FRAME_WIDTH-1:0] rd_row;
  logic [FRAME_WIDTH-1:0] alu_row;
  logic                   alu_hit;
  logic                   accept;
  logic [7:0]             col0;
  logic [7:0]             row0;
  logic [RSUM_W-1:0]      row_sum;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // Clamp the start to the last column and row.
  always_comb begin
    col0    = (in_data.x_start > 8'(FRAME_WIDTH - 1)) ? 8'(FRAME_WIDTH - 1) : in_data.x_start;
    row0    = (in_data.y_start > 8'(FRAME_HEIGHT - 1)) ? 8'(FRAME_HEIGHT - 1)
                                                       : in_data.y_start;
    row_sum = RSUM_W'(row0) + RSUM_W'(in_data.row_offset);
  end

  xsf_frame_mem #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .ROW_W        (ROW_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (addr_r),
    .wr_addr (addr_r),
    .wr_data (row_r),
    .rd_data (rd_row)
  );

  xsf_pixel_alu #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .COL_W       (COL_W),
    .IDX_W       (IDX_W)
  ) u_alu (
    .row_in     (row_r),
    .col        (col_r),
    .sprite_pix (sprite_r[SPRITE_PIXELS-1]),
    .row_out    (alu_row),
    .hit        (alu_hit)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    col_nxt       = col_r;
    sprite_nxt    = sprite_r;
    addr_nxt      = addr_r;
    pidx_nxt      = pidx_r;
    last_nxt      = last_r;
    oor_nxt       = oor_r;
    pixel_nxt     = pixel_r;
    acc_nxt       = acc_r;
    k_nxt         = k_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_ctl       = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt     = in_data.operation;
          col_nxt    = COL_W'(col0);
          sprite_nxt = in_data.sprite_bits;
          last_nxt   = in_data.last_row;
          pidx_nxt   = in_data.x_start[IDX_W-1:0];
          oor_nxt    = 1'b0;
          pixel_nxt  = 1'b0;
          k_nxt      = '0;
          state_nxt  = ST_OUT;
          case (in_data.operation)
            OP_FILL: begin
              mem_ctl.fill     = 1'b1;
              mem_ctl.fill_bit = in_data.fill_bit;
            end
            OP_DRAW: begin
              if (in_data.row_offset == 4'd0) begin
                acc_nxt = 1'b0;
              end
              addr_nxt = row_sum[ROW_W-1:0];
              // Drop a row below the bottom edge.
              if (row_sum < RSUM_W'(FRAME_HEIGHT)) begin
                state_nxt = ST_FETCH;
              end
            end
            OP_READ: begin
              addr_nxt = in_data.y_start[ROW_W-1:0];
              if (in_data.x_start >= 8'(FRAME_WIDTH) ||
                  in_data.y_start >= 8'(FRAME_HEIGHT)) begin
                oor_nxt = 1'b1;
              end else begin
                state_nxt = ST_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        mem_ctl.rd_en = 1'b1;
        state_nxt     = ST_LOAD;
      end
      ST_LOAD: begin
        if (op_r == OP_DRAW) begin
          row_nxt   = rd_row;
          state_nxt = ST_PIX;
        end else begin
          pixel_nxt = rd_row[pidx_r];
          state_nxt = ST_OUT;
        end
      end
      ST_PIX: begin
        row_nxt    = alu_row;
        acc_nxt    = acc_r | alu_hit;
        col_nxt    = col_r + COL_W'(1);
        sprite_nxt = sprite_r << 1;
        k_nxt      = k_r + PIX_CNT_W'(1);
        if (k_r == PIX_CNT_W'(SPRITE_PIXELS - 1)) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_ctl.wr_en = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        // Load the result once the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          case (op_r)
            OP_DRAW: begin
              out_data_nxt.collision   = acc_r;
              out_data_nxt.sprite_done = last_r;
            end
            OP_READ: begin
              out_data_nxt.pixel_value  = pixel_r;
              out_data_nxt.out_of_range = oor_r;
            end
            default: begin
            end
          endcase
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    col_r      <= col_nxt;
    sprite_r   <= sprite_nxt;
    addr_r     <= addr_nxt;
    pidx_r     <= pidx_nxt;
    last_r     <= last_nxt;
    oor_r      <= oor_nxt;
    pixel_r    <= pixel_nxt;
    k_r        <= k_nxt;
    row_r      <= row_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `XSF_ASSERT_NXT(a_accept_busy, accept, in_stall, "block not busy after accepting a word")
  `XSF_ASSERT_NXT(a_pix_to_write, (state_r == ST_PIX) && (k_r == PIX_CNT_W'(SPRITE_PIXELS - 1)),
                  state_r == ST_WRITE, "pixel loop did not end after the last sprite pixel")
  `XSF_ASSERT_NXT(a_write_to_out, state_r == ST_WRITE, state_r == ST_OUT,
                  "row write not followed by result")
  `XSF_ASSERT_IMP(a_read_fields, out_valid_r && (out_data_r.pixel_value ||
                  out_data_r.out_of_range), !out_data_r.collision && !out_data_r.sprite_done,
                  "read result carries draw fields")
  `XSF_ASSERT_IMP(a_oor_pixel, out_valid_r && out_data_r.out_of_range,
                  !out_data_r.pixel_value, "out-of-range read returned a set pixel")

endmodule

// ----- sim/tb_xor_sprite_framebuffer.sv -----
// Testbench for the XOR sprite framebuffer: directed, random and backpressure tests.
`timescale 1ns / 100ps

module tb_xor_sprite_framebuffer;
  import xsf_pkg::*;

  localparam int FB_W = FRAME_WIDTH_DEF;
  localparam int FB_H = FRAME_HEIGHT_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 1750;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic [FB_W-1:0] shadow_frame [FB_H];
  logic            shadow_hit;
  out_item_t       expected_flags_q [$];
  int              error_count = 0;
  int              words_sent = 0;
  int              hold_request = 0;
  bit              no_idle = 1'b0;
  int              last_x = 0;
  int              last_y = 0;

  xor_sprite_framebuffer #(
    .FRAME_WIDTH (FB_W),
    .FRAME_HEIGHT(FB_H)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  function automatic int idle_draw();
    if (no_idle) return 0;
    return $urandom_range(0, 7);
  endfunction

  function automatic in_item_t make_word(input logic [1:0] op, input int x, input int y,
                                         input int off, input int bits, input int last,
                                         input int fill);
    in_item_t w;
    w.operation   = op;
    w.x_start     = x[7:0];
    w.y_start     = y[7:0];
    w.row_offset  = off[3:0];
    w.sprite_bits = bits[7:0];
    w.last_row    = last[0];
    w.fill_bit    = fill[0];
    return w;
  endfunction

  // Update the shadow frame and return the flags the block should report.
  function automatic out_item_t frame_apply(input in_item_t w);
    out_item_t r;
    int        c0;
    int        r0;
    int        row;
    int        col;
    r = '0;
    case (w.operation)
      OP_FILL: begin
        for (int i = 0; i < FB_H; i++) shadow_frame[i] = {FB_W{w.fill_bit}};
      end
      OP_DRAW: begin
        if (w.row_offset == 0) shadow_hit = 1'b0;
        c0 = (w.x_start > FB_W - 1) ? FB_W - 1 : int'(w.x_start);
        r0 = (w.y_start > FB_H - 1) ? FB_H - 1 : int'(w.y_start);
        row = r0 + int'(w.row_offset);
        if (row < FB_H) begin
          for (int k = 0; k < SPRITE_PIXELS; k++) begin
            col = c0 + k;
            // drop pixels past the right edge
            if (col < FB_W && w.sprite_bits[SPRITE_PIXELS-1-k]) begin
              if (shadow_frame[row][col]) shadow_hit = 1'b1;
              shadow_frame[row][col] = ~shadow_frame[row][col];
            end
          end
        end
        r.collision   = shadow_hit;
        r.sprite_done = w.last_row;
      end
      OP_READ: begin
        if (w.x_start >= FB_W || w.y_start >= FB_H) r.out_of_range = 1'b1;
        else r.pixel_value = shadow_frame[w.y_start][w.x_start];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Called just after a falling edge; returns just after a falling edge, once the word has been accepted.
  task automatic send_word(input in_item_t w);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    expected_flags_q.push_back(frame_apply(w));
    words_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold until every pending result is back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_flags_q.size() != 0) @(negedge clk);
  endtask

  // Receiver: draw a stall length per word, or take a requested long hold.
  initial begin
    int n;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = idle_draw();
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_flags_q.size() == 0) begin
        report_error($sformatf("result word %b with nothing pending", out_data));
      end else begin
        want = expected_flags_q.pop_front();
        if (out_data.collision !== want.collision)
          report_error($sformatf("collision got %b want %b", out_data.collision,
                                 want.collision));
        if (out_data.pixel_value !== want.pixel_value)
          report_error($sformatf("pixel_value got %b want %b", out_data.pixel_value,
                                 want.pixel_value));
        if (out_data.sprite_done !== want.sprite_done)
          report_error($sformatf("sprite_done got %b want %b", out_data.sprite_done,
                                 want.sprite_done));
        if (out_data.out_of_range !== want.out_of_range)
          report_error($sformatf("out_of_range got %b want %b", out_data.out_of_range,
                                 want.out_of_range));
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a word.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic test_directed();
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_READ, FB_W - 1, FB_H - 1, 0, 0, 0, 0));
    send_word(make_word(OP_READ, FB_W, 0, 0, 0, 0, 0));
    send_word(make_word(OP_READ, 0, FB_H, 0, 0, 0, 0));
    send_word(make_word(OP_READ, 255, 255, 15, 255, 1, 1));
    send_word(make_word(OP_FILL, 0, 0, 0, 0, 0, 1));
    send_word(make_word(OP_READ, FB_W - 1, FB_H - 1, 0, 0, 0, 0));
    // every pixel is set: a full row turns pixels off
    send_word(make_word(OP_DRAW, 0, 0, 0, 8'hFF, 0, 0));
    send_word(make_word(OP_READ, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_FILL, 255, 255, 15, 255, 1, 0));
    send_word(make_word(OP_DRAW, 0, 0, 0, 8'hA5, 0, 0));
    // clear pixels staying clear is no collision
    send_word(make_word(OP_DRAW, 0, 0, 1, 8'h00, 0, 0));
    send_word(make_word(OP_DRAW, 0, 0, 2, 8'h80, 1, 0));
    send_word(make_word(OP_DRAW, 0, 0, 0, 8'h80, 0, 1));
    // accumulated collision holds over later rows
    send_word(make_word(OP_DRAW, 0, 0, 3, 8'h00, 1, 0));
    send_word(make_word(OP_DRAW, FB_W - 4, 5, 0, 8'hFF, 1, 0));
    send_word(make_word(OP_READ, FB_W - 1, 5, 0, 0, 0, 0));
    send_word(make_word(OP_READ, 0, 6, 0, 0, 0, 0));
    // start beyond the frame clamps to the last column and row
    send_word(make_word(OP_DRAW, 200, 200, 0, 8'hFF, 0, 0));
    send_word(make_word(OP_DRAW, 200, 200, 1, 8'hFF, 1, 0));
    send_word(make_word(OP_READ, FB_W - 1, FB_H - 1, 0, 0, 0, 0));
    send_word(make_word(OP_UNUSED, 255, 255, 15, 255, 1, 1));
    send_word(make_word(OP_FILL, 17, 3, 9, 8'h5A, 1, 1));
    send_word(make_word(OP_READ, 10, 10, 0, 0, 0, 0));
    send_word(make_word(OP_DRAW, 0, FB_H - 1, 15, 8'hFF, 1, 1));
  endtask

  task automatic send_sprite(input bit broken);
    int rows;
    int x;
    int y;
    rows = $urandom_range(1, 16);
    x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, FB_W - 1);
    y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, FB_H - 1);
    last_x = x;
    last_y = y;
    for (int r = 0; r < rows; r++) begin
      // a broken sprite has no end marker and, with more than one row, skips its start row
      if (broken && r == 0 && rows > 1) continue;
      send_word(make_word(OP_DRAW, x, y, r, $urandom_range(0, 255),
                          int'((r == rows - 1) && !broken), $urandom_range(0, 1)));
    end
  endtask

  task automatic test_random_traffic();
    int kind;
    int n;
    int x;
    int y;
    while (words_sent < RANDOM_WORDS) begin
      if (words_sent % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        send_sprite(1'b0);
      end else if (kind < 62) begin
        send_sprite(1'b1);
      end else if (kind < 82) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(0, 7) == 0) begin
            x = $urandom_range(0, 255);
            y = $urandom_range(0, 255);
          end else begin
            x = last_x + $urandom_range(0, 9);
            y = last_y + $urandom_range(0, 15);
          end
          send_word(make_word(OP_READ, x, y, $urandom_range(0, 15), $urandom_range(0, 255),
                              $urandom_range(0, 1), $urandom_range(0, 1)));
        end
      end else if (kind < 85) begin
        send_word(make_word(OP_FILL, $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 15), $urandom_range(0, 255),
                            $urandom_range(0, 1), $urandom_range(0, 1)));
      end else begin
        send_word(in_item_t'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    no_idle = 1'b1;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 2)
        send_word(make_word(OP_READ, $urandom_range(0, FB_W - 1), $urandom_range(0, FB_H - 1),
                            0, 0, 0, 0));
      else
        send_word(make_word(OP_DRAW, $urandom_range(0, FB_W - 1),
                            $urandom_range(0, FB_H - 1), i % 4, $urandom_range(0, 255),
                            int'(i % 4 == 3), 0));
    end
    no_idle = 1'b0;
    // hold off until every pending result is back
    wait_results_drained();
    repeat (5) send_word(make_word(OP_DRAW, $urandom_range(0, 255), $urandom_range(0, 255),
                                   0, $urandom_range(0, 255), 1, 0));
  endtask

  initial begin
    for (int i = 0; i < FB_H; i++) shadow_frame[i] = '0;
    shadow_hit = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random_traffic();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
